// ----- rtl/core/als_pkg.sv -----
// ----------------------------------------------------------------------------
// Addressable LED serializer package
// Shared types, register indexes and helpers for the serializer front and back.
// ----------------------------------------------------------------------------
package als_pkg;

  localparam int unsigned BitsPerPixel = 24;
  localparam int unsigned BitsLeftW    = $clog2(BitsPerPixel + 1);
  localparam int unsigned TicksW       = 16;
  localparam int unsigned CfgIdxW      = 3;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] RegZeroHigh = 3'd0;
  localparam logic [CfgIdxW-1:0] RegOneHigh  = 3'd1;
  localparam logic [CfgIdxW-1:0] RegZeroLow  = 3'd2;
  localparam logic [CfgIdxW-1:0] RegOneLow   = 3'd3;
  localparam logic [CfgIdxW-1:0] RegLatch    = 3'd4;

  // Reset values of the timing registers, in ticks
  localparam logic [TicksW-1:0] ZeroHighRst = 16'd25;
  localparam logic [TicksW-1:0] OneHighRst  = 16'd65;
  localparam logic [TicksW-1:0] ZeroLowRst  = 16'd70;
  localparam logic [TicksW-1:0] OneLowRst   = 16'd30;
  localparam logic [TicksW-1:0] LatchRst    = 16'd600;

  // Input item mode codes
  localparam logic [1:0] ModeTick  = 2'd0;
  localparam logic [1:0] ModeLoad  = 2'd1;
  localparam logic [1:0] ModeLatch = 2'd2;
  localparam logic [1:0] ModeNop   = 2'd3;

  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pixel_in_t;

  typedef struct packed {
    logic line_level;
    logic busy_res;
    logic rejected;
    logic pixel_done;
    logic latch_done;
  } result_t;

  typedef enum logic [1:0] {
    OP_TICK,
    OP_LOAD,
    OP_LATCH,
    OP_NOP
  } op_e;

  typedef struct packed {
    op_e                    op;
    logic [BitsPerPixel-1:0] pixel;  // green, red, blue, MSB first
  } cmd_t;

  // A zero length behaves as one tick.
  function automatic logic [TicksW-1:0] at_least_one(input logic [TicksW-1:0] v);
    return (v == '0) ? TicksW'(1) : v;
  endfunction

endpackage

// ----- rtl/core/addressable_led_serializer.sv -----
// ----------------------------------------------------------------------------
// Addressable LED serializer
// Single-wire pixel serializer for chained RGB LEDs, stepped by tick beats.
// ----------------------------------------------------------------------------
// Both queues hold two entries. A pushed beat is stored in the front queue,
// then executed into the result queue; empty goes low. Throughput: one beat
// per cycle while results have room, set by the back end's waveform update.
// Reset: asynchronous, active low; clears both queues and the waveform state,
// and loads the timing registers with their default tick counts.
// ----------------------------------------------------------------------------
module addressable_led_serializer import als_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  // Input beats
  input  logic               push,
  output logic               full,
  input  pixel_in_t          pixel_i,
  // Result beats
  output logic               empty,
  input  logic               pop,
  output result_t            result_o,
  // Configuration writes
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [TicksW-1:0]  cfg_data_i
);

  // Command hand-off between the front and back ends
  logic cmd_valid;
  logic cmd_pop;
  cmd_t cmd;

  // Front end: decode the mode and hold up to two commands
  als_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .pixel_i     (pixel_i),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_pop_i   (cmd_pop)
  );

  // Back end: advance the line waveform and queue one result per command
  als_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .empty       (empty),
    .pop         (pop),
    .result_o    (result_o)
  );

endmodule

// ----- rtl/core/als_front.sv -----
// ----------------------------------------------------------------------------
// Serializer front end
// Accepts input beats, decodes the mode into a command and queues it.
// ----------------------------------------------------------------------------
module als_front import als_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push,
  output logic      full,
  input  pixel_in_t pixel_i,
  output logic      cmd_valid_o,
  output cmd_t      cmd_o,
  input  logic      cmd_pop_i
);

  cmd_t       mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;
  logic       wr_en;
  logic       rd_en;
  cmd_t       cmd_new;

  // Classify the beat
  always_comb begin
    cmd_new.pixel = {pixel_i.green, pixel_i.red, pixel_i.blue};
    unique case (pixel_i.mode)
      ModeTick:  cmd_new.op = OP_TICK;
      ModeLoad:  cmd_new.op = OP_LOAD;
      ModeLatch: cmd_new.op = OP_LATCH;
      ModeNop:   cmd_new.op = OP_NOP;
      default:   cmd_new.op = OP_NOP;
    endcase
  end

  assign full        = (count_q == 2'd2);
  assign wr_en       = push && !full;
  assign cmd_valid_o = (count_q != 2'd0);
  assign rd_en       = cmd_pop_i && cmd_valid_o;
  assign cmd_o       = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_en ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = rd_en ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q + {1'b0, wr_en} - {1'b0, rd_en};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_ptr_q] <= cmd_new;
    end
  end

endmodule

// ----- rtl/core/als_back.sv -----
// ----------------------------------------------------------------------------
// Serializer back end
// Runs the line waveform one command a cycle while the result queue has room, and queues the result beats.
// ----------------------------------------------------------------------------
module als_back import als_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cmd_valid_i,
  input  cmd_t               cmd_i,
  output logic               cmd_pop_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [TicksW-1:0]  cfg_data_i,
  output logic               empty,
  input  logic               pop,
  output result_t            result_o
);

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_HIGH,
    PH_LOW,
    PH_LATCH
  } phase_e;

  logic [TicksW-1:0] zero_high_q, one_high_q, zero_low_q, one_low_q, latch_q;

  phase_e                  phase_q, phase_d;
  logic [BitsPerPixel-1:0] shift_q, shift_d, shift_nx;
  logic [BitsLeftW-1:0]    bits_q, bits_d, bits_nx;
  logic [TicksW-1:0]       ticks_q, ticks_d;
  logic                    rejected, pixel_done, latch_done;
  logic                    exec;
  result_t                 res_new;

  result_t    res_mem_q [2];
  logic       res_wr_q, res_rd_q;
  logic [1:0] res_cnt_q;
  logic       res_pop;
  logic       res_space;

  // Configuration: always ready
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      zero_high_q <= ZeroHighRst;
      one_high_q  <= OneHighRst;
      zero_low_q  <= ZeroLowRst;
      one_low_q   <= OneLowRst;
      latch_q     <= LatchRst;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        RegZeroHigh: zero_high_q <= cfg_data_i;
        RegOneHigh:  one_high_q  <= cfg_data_i;
        RegZeroLow:  zero_low_q  <= cfg_data_i;
        RegOneLow:   one_low_q   <= cfg_data_i;
        RegLatch:    latch_q     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Execute one command whenever the result queue can take its beat
  assign res_pop   = pop && !empty;
  assign res_space = (res_cnt_q != 2'd2) || res_pop;
  assign exec      = cmd_valid_i && res_space;
  assign cmd_pop_o = exec;

  assign shift_nx = {shift_q[BitsPerPixel-2:0], 1'b0};
  assign bits_nx  = (bits_q == '0) ? '0 : bits_q - BitsLeftW'(1);

  always_comb begin
    phase_d    = phase_q;
    shift_d    = shift_q;
    bits_d     = bits_q;
    ticks_d    = ticks_q;
    rejected   = 1'b0;
    pixel_done = 1'b0;
    latch_done = 1'b0;
    unique case (cmd_i.op)
      OP_LOAD: begin
        if (phase_q != PH_IDLE) begin
          rejected = 1'b1;
        end else begin
          shift_d = cmd_i.pixel;
          bits_d  = BitsLeftW'(BitsPerPixel);
          phase_d = PH_HIGH;
          ticks_d = at_least_one(cmd_i.pixel[BitsPerPixel-1] ? one_high_q : zero_high_q);
        end
      end
      OP_LATCH: begin
        if (phase_q != PH_IDLE) begin
          rejected = 1'b1;
        end else begin
          phase_d = PH_LATCH;
          ticks_d = at_least_one(latch_q);
        end
      end
      OP_TICK: begin
        if (phase_q != PH_IDLE) begin
          if (ticks_q > TicksW'(1)) begin
            ticks_d = ticks_q - TicksW'(1);
          end else begin
            unique case (phase_q)
              PH_HIGH: begin
                phase_d = PH_LOW;
                ticks_d = at_least_one(shift_q[BitsPerPixel-1] ? one_low_q : zero_low_q);
              end
              PH_LOW: begin
                shift_d = shift_nx;
                bits_d  = bits_nx;
                if (bits_nx == '0) begin
                  phase_d    = PH_IDLE;
                  ticks_d    = '0;
                  pixel_done = 1'b1;
                end else begin
                  phase_d = PH_HIGH;
                  ticks_d = at_least_one(shift_nx[BitsPerPixel-1] ? one_high_q : zero_high_q);
                end
              end
              PH_LATCH: begin
                phase_d    = PH_IDLE;
                ticks_d    = '0;
                latch_done = 1'b1;
              end
              default: ;
            endcase
          end
        end
      end
      OP_NOP: ;
      default: ;
    endcase
    res_new.line_level = (phase_d == PH_HIGH);
    res_new.busy_res   = (phase_d != PH_IDLE);
    res_new.rejected   = rejected;
    res_new.pixel_done = pixel_done;
    res_new.latch_done = latch_done;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      shift_q <= '0;
      bits_q  <= '0;
      ticks_q <= '0;
    end else if (exec) begin
      phase_q <= phase_d;
      shift_q <= shift_d;
      bits_q  <= bits_d;
      ticks_q <= ticks_d;
    end
  end

  // Result queue
  assign empty    = (res_cnt_q == 2'd0);
  assign result_o = res_mem_q[res_rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_wr_q  <= 1'b0;
      res_rd_q  <= 1'b0;
      res_cnt_q <= 2'd0;
    end else begin
      if (exec) begin
        res_wr_q <= ~res_wr_q;
      end
      if (res_pop) begin
        res_rd_q <= ~res_rd_q;
      end
      res_cnt_q <= res_cnt_q + {1'b0, exec} - {1'b0, res_pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (exec) begin
      res_mem_q[res_wr_q] <= res_new;
    end
  end

endmodule
